/* rtl/core/key_dbnc_pkg.sv */
// ----------------------------------------------------------------------------
// key_dbnc_pkg
// Shared types and constants for the key debounce and auto-repeat block.
// ----------------------------------------------------------------------------
`default_nettype none

package key_dbnc_pkg;

    localparam int DELAY_BITS = 24;
    localparam int KEY_BITS   = 8;
    localparam int CFG_IDX_BITS = 3;

    typedef logic [DELAY_BITS-1:0] delay_t;
    typedef logic [KEY_BITS-1:0]   key_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DEBOUNCE_DELAY     = 3'd0,
        CFG_FIRST_REPEAT_DELAY = 3'd1,
        CFG_REPEAT_DELAY       = 3'd2,
        CFG_DOWN_KEY_CODE      = 3'd3,
        CFG_UP_KEY_CODE        = 3'd4
    } cfg_idx_t;

    localparam delay_t RST_DEBOUNCE_DELAY     = 24'd30000;
    localparam delay_t RST_FIRST_REPEAT_DELAY = 24'd350000;
    localparam delay_t RST_REPEAT_DELAY       = 24'd150000;
    localparam key_t   RST_DOWN_KEY_CODE      = 8'd114;
    localparam key_t   RST_UP_KEY_CODE        = 8'd115;

endpackage

`default_nettype wire

/* rtl/core/key_debounce_auto_repeat.sv */
// A word is taken into the input register, and its result moves into the
// result register once that register is free.
// Throughput: one time sample per clock unless m_ready stalls; the path is one
// delay add and one deadline compare on the registered key state.
// Reset: synchronous active-low aresetn clears key state, the delay and key
// registers to their defaults and both handshake stages.
// ----------------------------------------------------------------------------
// key_debounce_auto_repeat
// Debounces a key code stream and generates typematic down/up events.
// ----------------------------------------------------------------------------
`default_nettype none

module key_debounce_auto_repeat
    import key_dbnc_pkg::*;
#(
    parameter int TIME_BITS = 48
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [DELAY_BITS-1:0]   cfg_wdata,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [TIME_BITS-1:0]    s_now_us,
    input  wire logic [KEY_BITS-1:0]     s_key_code,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic                         m_down_event,
    output logic                         m_up_event
);

    typedef logic [TIME_BITS-1:0] time_t;

    // configuration
    delay_t debounce_delay_reg;
    delay_t first_repeat_delay_reg;
    delay_t repeat_delay_reg;
    key_t   down_key_code_reg;
    key_t   up_key_code_reg;

    // input stage
    logic   in_vld_reg;
    time_t  now_reg;
    key_t   key_reg;

    // key state
    key_t   held_key_reg;
    time_t  deadline_reg;
    logic   armed_reg;
    logic   repeating_reg;

    // result stage
    logic   out_vld_reg;
    logic   down_reg;
    logic   up_reg;

    logic   advance;
    logic   key_chg;
    time_t  deadline_eff;
    logic   armed_eff;
    logic   repeating_eff;
    logic   expire;
    logic   hit_down;
    logic   hit_up;
    time_t  reload_delay;
    time_t  deadline_next;
    logic   armed_next;
    logic   repeating_next;
    logic   down_next;
    logic   up_next;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_comb begin
        key_chg       = (key_reg != held_key_reg);
        deadline_eff  = key_chg ? now_reg + time_t'(debounce_delay_reg) : deadline_reg;
        armed_eff     = key_chg || armed_reg;
        repeating_eff = !key_chg && repeating_reg;
        expire        = armed_eff && (deadline_eff < now_reg);
        hit_down      = (key_reg == down_key_code_reg);
        hit_up        = !hit_down && (key_reg == up_key_code_reg);
        reload_delay  = repeating_eff ? time_t'(repeat_delay_reg)
                                      : time_t'(first_repeat_delay_reg);

        deadline_next  = deadline_eff;
        armed_next     = armed_eff;
        repeating_next = repeating_eff;
        down_next      = 1'b0;
        up_next        = 1'b0;
        if (expire) begin
            deadline_next  = now_reg + reload_delay;
            repeating_next = 1'b1;
            down_next      = hit_down;
            up_next        = hit_up;
            // any other key stops the repeat
            armed_next     = hit_down || hit_up;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_delay_reg     <= RST_DEBOUNCE_DELAY;
            first_repeat_delay_reg <= RST_FIRST_REPEAT_DELAY;
            repeat_delay_reg       <= RST_REPEAT_DELAY;
            down_key_code_reg      <= RST_DOWN_KEY_CODE;
            up_key_code_reg        <= RST_UP_KEY_CODE;
            in_vld_reg             <= 1'b0;
            held_key_reg           <= '0;
            deadline_reg           <= '0;
            armed_reg              <= 1'b0;
            repeating_reg          <= 1'b0;
            out_vld_reg            <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_DEBOUNCE_DELAY:     debounce_delay_reg     <= cfg_wdata;
                    CFG_FIRST_REPEAT_DELAY: first_repeat_delay_reg <= cfg_wdata;
                    CFG_REPEAT_DELAY:       repeat_delay_reg       <= cfg_wdata;
                    CFG_DOWN_KEY_CODE:      down_key_code_reg      <= cfg_wdata[KEY_BITS-1:0];
                    CFG_UP_KEY_CODE:        up_key_code_reg        <= cfg_wdata[KEY_BITS-1:0];
                    default: begin
                    end
                endcase
            end

            if (s_ready) begin
                in_vld_reg <= s_valid;
            end

            if (advance) begin
                held_key_reg  <= key_reg;
                deadline_reg  <= deadline_next;
                armed_reg     <= armed_next;
                repeating_reg <= repeating_next;
                out_vld_reg   <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg   <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            now_reg <= s_now_us;
            key_reg <= s_key_code;
        end
        if (advance) begin
            down_reg <= down_next;
            up_reg   <= up_next;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_down_event = down_reg;
    assign m_up_event   = up_reg;

    // down takes precedence, so both never fire together
    a_one_event: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> !(down_next && up_next))
        else $error("down and up event in the same word");

    // an event leaves the key armed and in repeat
    a_event_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (down_next || up_next)) |=> (armed_reg && repeating_reg))
        else $error("event fired without arming repeat");

    // expiry on a foreign key disarms
    a_foreign_disarm: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && expire && !down_next && !up_next) |=> !armed_reg)
        else $error("foreign key expiry left the deadline armed");

    // a key change always re-arms unless it expired on a foreign key
    a_change_arms: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && key_chg && !expire) |=> (armed_reg && !repeating_reg))
        else $error("key change did not re-arm debounce");

endmodule

`default_nettype wire

/* bench/key_debounce_auto_repeat_test.sv */
// ----------------------------------------------------------------------------
// key_debounce_auto_repeat_test
// Self-checking bench for the key debounce and auto-repeat block. Time samples
// go in on the valid/ready input. A local copy of the debounce and repeat
// timer predicts every down/up word, and a checker compares each result word
// with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module key_debounce_auto_repeat_test;
    import key_dbnc_pkg::*;

    localparam int TIME_BITS   = 48;
    localparam int GAP_PERCENT = 19;
    localparam int HOLD_CYCLES = 250;

    typedef logic [TIME_BITS-1:0] usec_t;
    typedef struct packed {
        logic down;
        logic up;
    } key_events_t;

    logic                    aclk         = 1'b0;
    logic                    aresetn      = 1'b0;
    logic                    cfg_wr_en    = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index    = '0;
    delay_t                  cfg_wdata    = '0;
    logic                    s_valid      = 1'b0;
    logic                    s_ready;
    usec_t                   s_now_us     = '0;
    key_t                    s_key_code   = '0;
    logic                    m_valid;
    logic                    m_ready      = 1'b0;
    logic                    m_down_event;
    logic                    m_up_event;

    // local copy of the registers and the timer state
    delay_t debounce_us     = RST_DEBOUNCE_DELAY;
    delay_t first_repeat_us = RST_FIRST_REPEAT_DELAY;
    delay_t repeat_us       = RST_REPEAT_DELAY;
    key_t   down_code       = RST_DOWN_KEY_CODE;
    key_t   up_code         = RST_UP_KEY_CODE;
    key_t   held_key        = '0;
    usec_t  deadline        = '0;
    logic   armed           = 1'b0;
    logic   repeating       = 1'b0;

    key_events_t pending_events[$];
    int          mismatch_count = 0;
    bit          gaps_on        = 1'b1;
    bit          stalls_on      = 1'b1;
    int          hold_requests  = 0;
    int          hold_seen      = 0;
    int          hold_left      = 0;
    usec_t       clock_us       = '0;

    key_debounce_auto_repeat #(
        .TIME_BITS(TIME_BITS)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_now_us    (s_now_us),
        .s_key_code  (s_key_code),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_down_event(m_down_event),
        .m_up_event  (m_up_event)
    );

    always #5 aclk = ~aclk;

    function automatic key_events_t next_key_events(input usec_t now, input key_t key);
        key_events_t ev;
        ev = '0;
        if (key != held_key) begin
            held_key  = key;
            deadline  = now + usec_t'(debounce_us);
            armed     = 1'b1;
            repeating = 1'b0;
        end
        // strict compare, so a wrapped deadline fires on the next sample
        if (armed && deadline < now) begin
            if (repeating) begin
                deadline = now + usec_t'(repeat_us);
            end else begin
                repeating = 1'b1;
                deadline  = now + usec_t'(first_repeat_us);
            end
            if (key == down_code) begin
                ev.down = 1'b1;
            end else if (key == up_code) begin
                ev.up = 1'b1;
            end else begin
                armed = 1'b0;
            end
        end
        return ev;
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        $display("mismatch at %0t: %s, expected %0d, got %0d", $time, what, want, got);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : check_words
        key_events_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_events.size() == 0) begin
                    flag_mismatch("result word with nothing pending", 0,
                                  int'({m_down_event, m_up_event}));
                end else begin
                    want = pending_events.pop_front();
                    if (want.down !== m_down_event)
                        flag_mismatch("down_event", int'(want.down), int'(m_down_event));
                    if (want.up !== m_up_event)
                        flag_mismatch("up_event", int'(want.up), int'(m_up_event));
                end
            end
            if (s_valid && s_ready)
                pending_events.push_back(next_key_events(s_now_us, s_key_code));
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= !(stalls_on && $urandom_range(99) < GAP_PERCENT);
        end
    end

    task automatic send_sample(input usec_t now, input key_t key);
        // each idle step is drawn anew, so the idle share follows the gap rate
        while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_now_us   <= now;
        s_key_code <= key;
        // ready is stable at the falling edge, so this predicts the next rising one
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
    endtask

    task automatic tick_key(input int unsigned dt, input key_t key);
        clock_us += usec_t'(dt);
        send_sample(clock_us, key);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_events.size() != 0);
    endtask

    task automatic load_config(input delay_t deb, input delay_t first, input delay_t rep,
                               input key_t dn, input key_t up);
        cfg_idx_t regs[5];
        delay_t   vals[5];
        regs = '{CFG_DEBOUNCE_DELAY, CFG_FIRST_REPEAT_DELAY, CFG_REPEAT_DELAY,
                 CFG_DOWN_KEY_CODE, CFG_UP_KEY_CODE};
        vals = '{deb, first, rep, delay_t'(dn), delay_t'(up)};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en       <= 1'b0;
        debounce_us     = deb;
        first_repeat_us = first;
        repeat_us       = rep;
        down_code       = dn;
        up_code         = up;
    endtask

    function automatic delay_t pick_delay();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return delay_t'($urandom);
            default: return delay_t'($urandom_range(60, 1));
        endcase
    endfunction

    function automatic key_t pick_code();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return key_t'($urandom);
        endcase
    endfunction

    // held keys with random content, short runs act as contact bounce
    task automatic run_key_stream(input int count, input int step_max);
        key_t key;
        int   run_len;
        int   sent;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(9))
                0, 1, 2, 3: key = down_code;
                4, 5, 6:    key = up_code;
                7:          key = '0;
                default:    key = key_t'($urandom);
            endcase
            run_len = $urandom_range(12, 1);
            for (int i = 0; i < run_len && sent < count; i++) begin
                if ($urandom_range(39) == 0) begin
                    // noise: any time, any key, time may run backwards
                    send_sample(usec_t'({$urandom, $urandom}), key_t'($urandom));
                end else begin
                    if ($urandom_range(19) == 0)
                        clock_us += usec_t'($urandom);
                    else
                        clock_us += usec_t'($urandom_range(step_max));
                    send_sample(clock_us, key);
                end
                sent++;
            end
        end
    endtask

    task automatic test_default_timing();
        tick_key(1000, 8'd114);
        tick_key(30000, 8'd114);
        tick_key(1, 8'd114);
        tick_key(350000, 8'd114);
        tick_key(1, 8'd114);
        tick_key(150001, 8'd114);
        tick_key(10, 8'd115);
        tick_key(30001, 8'd115);
        tick_key(10, 8'd0);
        tick_key(30001, 8'd0);
        tick_key(400000, 8'd0);
        tick_key(5, 8'd200);
        tick_key(30001, 8'd200);
    endtask

    task automatic test_time_wrap();
        // jump to the top of the time range, deadlines wrap past zero
        clock_us = {TIME_BITS{1'b1}} - usec_t'(15);
        tick_key(0, 8'd114);
        tick_key(15, 8'd114);
        tick_key(1, 8'd114);
    endtask

    task automatic test_zero_codes();
        wait_drained();
        load_config('0, '0, '0, '0, '0);
        tick_key(1, 8'd0);
        tick_key(1, 8'd0);
        tick_key(0, 8'd0);
        tick_key(1, 8'd0);
        wait_drained();
        load_config('1, '1, '0, '1, '1);
        tick_key(1, 8'd255);
        tick_key(24'hFFFFFF, 8'd255);
        tick_key(1, 8'd255);
        tick_key(1, 8'd255);
        wait_drained();
        load_config(24'd2, '0, '0, 8'd1, '0);
        tick_key(1, 8'd5);
        tick_key(1, 8'd0);
        tick_key(3, 8'd0);
    endtask

    task automatic test_back_to_back();
        wait_drained();
        load_config(24'd4, 24'd9, 24'd3, 8'd114, 8'd115);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_key_stream(60, 6);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_backpressure();
        wait_drained();
        load_config(24'd7, 24'd20, 24'd5, pick_code(), pick_code());
        hold_requests <= hold_requests + 1;
        run_key_stream(30, 12);
        // sender sits idle until every word is back
        wait_drained();
        run_key_stream(20, 12);
    endtask

    task automatic test_random_phases(input int phases);
        key_t dn;
        for (int p = 0; p < phases; p++) begin
            wait_drained();
            dn = pick_code();
            load_config(pick_delay(), pick_delay(), pick_delay(), dn,
                        ($urandom_range(7) == 0) ? dn : pick_code());
            run_key_stream(50, $urandom_range(40, 1));
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_timing();
        test_time_wrap();
        test_zero_codes();
        test_back_to_back();
        test_backpressure();
        test_random_phases(8);
        s_valid <= 1'b0;
        for (int n = 0; n < 2000 && pending_events.size() != 0; n++) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (pending_events.size() != 0)
            flag_mismatch("result words never arrived", 0, pending_events.size());
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout at %0t", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
